// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check, also evaluated during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pcbd_pkg.sv -----
// package with sizes and shared types of the passive cell balance decider
`default_nettype none
package pcbd_pkg;

  localparam int MODULES         = 8;
  localparam int TAPS_PER_MODULE = 16;

  localparam int VOLT_W = 16;
  localparam int ID_W   = 6;
  localparam int MOD_W  = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int CNT_W  = $clog2(TAPS_PER_MODULE + 1);
  localparam int SUM_W  = VOLT_W + ((TAPS_PER_MODULE > 1) ? $clog2(TAPS_PER_MODULE) : 1);
  localparam int STEP_W = $clog2(SUM_W);

  // register indexes on the apb port
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_MARKER    = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/passive_cell_balance_decider.sv -----
// top level of the passive cell balance decider
// Usage:
//   Tap samples enter on start while busy is low; each carries module_index,
//   cell_voltage and last_sample. A sample that is not last is accumulated
//   and busy stays low, so samples may arrive every cycle.
//   A sample with last_sample high is accumulated and then starts the
//   evaluation walk: busy goes high, each module with data runs through the
//   shared bit-serial divider (SUM_W = 20 quotient bits), modules without
//   data skip the divider, then one decision per module follows on
//   result_valid in consecutive cycles, module 0 first, last_decision on the
//   final one. busy falls in the cycle that shows the last decision.
//   Each decision is on the result ports for exactly one cycle; the receiver
//   cannot stall and must take it then.
//   Registers on the APB port: 0x0 passive_enable, 0x4 balance_threshold,
//   0x8 invalid_marker; pready is always high. Write them only while idle.
//   Reset (rst, synchronous) clears sums, counts and registers to their
//   defaults (enable 0, threshold 100, marker 0) and returns to idle.
`default_nettype none
`include "assert_macros.svh"
module passive_cell_balance_decider (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire [5:0]  module_index,
  input  wire [15:0] cell_voltage,
  input  wire        last_sample,
  output logic       result_valid,
  output logic [5:0] module_id,
  output logic       balance_on,
  output logic [15:0] module_average,
  output logic       no_valid_data,
  output logic       last_decision,
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [3:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  localparam int MOD_W  = pcbd_pkg::MOD_W;
  localparam int CNT_W  = pcbd_pkg::CNT_W;
  localparam int SUM_W  = pcbd_pkg::SUM_W;
  localparam int VOLT_W = pcbd_pkg::VOLT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [6:0]       MODULES_V = 7'(pcbd_pkg::MODULES);
  localparam logic [MOD_W-1:0] MOD_LAST  = MOD_W'(pcbd_pkg::MODULES - 1);

  logic                passive_enable;
  logic [VOLT_W-1:0]   balance_threshold;
  logic [VOLT_W-1:0]   invalid_marker;

  logic [1:0]          state;
  logic [MOD_W-1:0]    idx;
  logic [VOLT_W-1:0]   lowest_average;

  logic [SUM_W-1:0]    tap_sum       [pcbd_pkg::MODULES];
  logic [CNT_W-1:0]    valid_count   [pcbd_pkg::MODULES];
  logic [VOLT_W-1:0]   average_store [pcbd_pkg::MODULES];
  logic [pcbd_pkg::MODULES-1:0] has_data;

  logic                cfg_write;
  logic                accept;
  logic [MOD_W-1:0]    rd_idx;
  logic [SUM_W-1:0]    sum_rd;
  logic [CNT_W-1:0]    cnt_rd;
  logic                acc_hit;
  logic                last_idx;

  pcbd_pkg::div_req_t  div_req;
  pcbd_pkg::div_rsp_t  div_rsp;
  logic [VOLT_W-1:0]   quot16;

  logic [VOLT_W-1:0]   emit_avg;
  logic [VOLT_W:0]     emit_diff;
  logic                emit_on;

  // apb
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      passive_enable    <= 1'b0;
      balance_threshold <= 16'd100;
      invalid_marker    <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        pcbd_pkg::REG_ENABLE:    passive_enable    <= pwdata[0];
        pcbd_pkg::REG_THRESHOLD: balance_threshold <= pwdata[VOLT_W-1:0];
        pcbd_pkg::REG_MARKER:    invalid_marker    <= pwdata[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pcbd_pkg::REG_ENABLE:    prdata = {31'd0, passive_enable};
      pcbd_pkg::REG_THRESHOLD: prdata = {16'd0, balance_threshold};
      pcbd_pkg::REG_MARKER:    prdata = {16'd0, invalid_marker};
      default:                 prdata = '0;
    endcase
  end

  // accumulation
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign rd_idx   = busy ? idx : module_index[MOD_W-1:0];
  assign sum_rd   = tap_sum[rd_idx];
  assign cnt_rd   = valid_count[rd_idx];
  assign last_idx = (idx == MOD_LAST);
  assign acc_hit  = accept && ({1'b0, module_index} < MODULES_V) &&
                    (cell_voltage != invalid_marker) &&
                    (cnt_rd < CNT_W'(pcbd_pkg::TAPS_PER_MODULE));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < pcbd_pkg::MODULES; m++) begin
        tap_sum[m]     <= '0;
        valid_count[m] <= '0;
      end
    end else if (acc_hit) begin
      tap_sum[rd_idx]     <= sum_rd + SUM_W'(cell_voltage);
      valid_count[rd_idx] <= cnt_rd + 1'b1;
    end else if (state == ST_EVAL) begin
      tap_sum[rd_idx]     <= '0;
      valid_count[rd_idx] <= '0;
    end
  end

  // shared divider
  assign div_req.valid    = (state == ST_EVAL) && (cnt_rd != '0);
  assign div_req.dividend = sum_rd;
  assign div_req.divisor  = cnt_rd;
  assign quot16           = div_rsp.quotient[VOLT_W-1:0];

  pcbd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && last_sample) begin
            state <= ST_EVAL;
            idx   <= '0;
          end
        end
        ST_EVAL: begin
          if (cnt_rd != '0) begin
            state <= ST_WAIT;
          end else if (last_idx) begin
            state <= ST_EMIT;
            idx   <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_WAIT: begin
          if (div_rsp.done) begin
            if (last_idx) begin
              state <= ST_EMIT;
              idx   <= '0;
            end else begin
              state <= ST_EVAL;
              idx   <= idx + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (last_idx) begin
            state <= ST_IDLE;
            idx   <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          idx   <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && last_sample) begin
      lowest_average <= '1;
    end else if (state == ST_WAIT && div_rsp.done && quot16 < lowest_average) begin
      lowest_average <= quot16;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      has_data[idx] <= (cnt_rd != '0);
      if (cnt_rd == '0) begin
        average_store[idx] <= '0;
      end
    end else if (state == ST_WAIT && div_rsp.done) begin
      average_store[idx] <= quot16;
    end
  end

  // decisions
  assign emit_avg  = average_store[idx];
  assign emit_diff = {1'b0, emit_avg} - {1'b0, lowest_average};
  assign emit_on   = passive_enable && has_data[idx] && !emit_diff[VOLT_W] &&
                     (emit_diff[VOLT_W-1:0] > balance_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT) begin
      module_id      <= 6'(idx);
      balance_on     <= emit_on;
      module_average <= emit_avg;
      no_valid_data  <= !has_data[idx];
      last_decision  <= last_idx;
    end
  end

  `ASSERT_CLK(a_last_has_valid, (result_valid && last_decision) |=> !result_valid,
              "transaction after the last decision")
  `ASSERT_CLK(a_burst, (result_valid && !last_decision) |=> result_valid,
              "gap inside the decision burst")
  `ASSERT_CLK(a_eval_busy, (accept && last_sample) |=> busy,
              "evaluation did not start after the last sample")
  `ASSERT_CLK(a_div_only_eval, div_rsp.done |-> (state == ST_WAIT),
              "divider result outside the wait state")

endmodule
`default_nettype wire

// ----- rtl/pcbd_div.sv -----
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
`include "assert_macros.svh"
module pcbd_div (
  input  wire               clk,
  input  wire               rst,
  input  wire pcbd_pkg::div_req_t req,
  output pcbd_pkg::div_rsp_t rsp
);

  logic                          run;
  logic                          done;
  logic [pcbd_pkg::STEP_W-1:0]   step;
  logic [pcbd_pkg::CNT_W-1:0]    rem;
  logic [pcbd_pkg::CNT_W-1:0]    dvs;
  logic [pcbd_pkg::SUM_W-1:0]    quo;
  logic [pcbd_pkg::CNT_W:0]      shifted;
  logic [pcbd_pkg::CNT_W:0]      diff;
  logic                          qbit;

  assign shifted = {rem, quo[pcbd_pkg::SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign qbit    = ~diff[pcbd_pkg::CNT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.valid) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == pcbd_pkg::STEP_W'(pcbd_pkg::SUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      rem <= '0;
      dvs <= req.divisor;
      quo <= req.dividend;
    end else if (run) begin
      rem <= qbit ? diff[pcbd_pkg::CNT_W-1:0] : shifted[pcbd_pkg::CNT_W-1:0];
      quo <= {quo[pcbd_pkg::SUM_W-2:0], qbit};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  `ASSERT_CLK(a_done_pulse, done |=> !done, "divider done longer than one cycle")
  `ASSERT_CLK(a_start_idle, req.valid |-> !run, "divider started while running")

endmodule
`default_nettype wire

// ----- test/passive_cell_balance_decider_test.sv -----
// testbench for the passive cell balance decider: queued tap samples, predicted decisions
`timescale 1ns / 100ps

module passive_cell_balance_decider_test;

  typedef struct packed {
    logic [5:0]  idx;
    logic [15:0] volt;
    logic        last;
  } tap_sample_t;

  typedef struct packed {
    logic [5:0]  id;
    logic        on;
    logic [15:0] avg;
    logic        nodata;
    logic        fin;
  } decision_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [5:0]  module_index = '0;
  logic [15:0] cell_voltage = '0;
  logic        last_sample = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy;
  logic        result_valid;
  logic [5:0]  module_id;
  logic        balance_on;
  logic [15:0] module_average;
  logic        no_valid_data;
  logic        last_decision;
  logic [31:0] prdata;
  logic        pready;

  passive_cell_balance_decider dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .module_index(module_index), .cell_voltage(cell_voltage), .last_sample(last_sample),
    .result_valid(result_valid), .module_id(module_id), .balance_on(balance_on),
    .module_average(module_average), .no_valid_data(no_valid_data),
    .last_decision(last_decision),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  tap_sample_t      tap_queue[$];
  decision_t        decisions_due[$];
  tap_sample_t      head;
  logic             taken = 1'b0;
  int               gap_pct = 18;
  int               mismatch_count = 0;

  logic             cfg_enable = 1'b0;
  logic [15:0]      cfg_threshold = 16'd100;
  logic [15:0]      cfg_marker = 16'd0;
  logic [pcbd_pkg::SUM_W-1:0] tap_total [pcbd_pkg::MODULES];
  logic [pcbd_pkg::CNT_W-1:0] tap_count [pcbd_pkg::MODULES];

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s: expected %0h, got %0h", what, want, got);
  endfunction

  function automatic void clear_pass();
    int m;
    for (m = 0; m < pcbd_pkg::MODULES; m++) begin
      tap_total[m] = '0;
      tap_count[m] = '0;
    end
  endfunction

  function automatic void absorb_sample(input tap_sample_t s);
    logic [15:0] avg [pcbd_pkg::MODULES];
    logic [15:0] lowest;
    logic        has;
    decision_t   d;
    int          m;
    int          mi;
    mi = s.idx;
    if (mi < pcbd_pkg::MODULES && s.volt != cfg_marker &&
        tap_count[mi] < pcbd_pkg::TAPS_PER_MODULE) begin
      tap_total[mi] += s.volt;
      tap_count[mi] += 1'b1;
    end
    if (!s.last) return;
    lowest = 16'hFFFF;
    for (m = 0; m < pcbd_pkg::MODULES; m++) begin
      if (tap_count[m] != 0) begin
        avg[m] = 16'(tap_total[m] / tap_count[m]);
        if (avg[m] < lowest) lowest = avg[m];
      end else begin
        avg[m] = '0;
      end
    end
    for (m = 0; m < pcbd_pkg::MODULES; m++) begin
      has = (tap_count[m] != 0);
      d.id = 6'(m);
      d.on = cfg_enable && has && avg[m] >= lowest && (avg[m] - lowest) > cfg_threshold;
      d.avg = avg[m];
      d.nodata = !has;
      d.fin = (m == pcbd_pkg::MODULES - 1);
      decisions_due.push_back(d);
    end
    clear_pass();
  endfunction

  // driver: new transaction only once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (tap_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        head = tap_queue.pop_front();
        start <= 1'b1;
        module_index <= head.idx;
        cell_voltage <= head.volt;
        last_sample <= head.last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted samples, check every decision
  always @(posedge clk) begin : watch
    decision_t want;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) absorb_sample('{module_index, cell_voltage, last_sample});
      if (result_valid) begin
        if (decisions_due.size() == 0) begin
          flag_mismatch("unexpected decision, module_id", 32'd0, module_id);
        end else begin
          want = decisions_due.pop_front();
          if (module_id !== want.id) flag_mismatch("module_id", want.id, module_id);
          if (balance_on !== want.on) flag_mismatch("balance_on", want.on, balance_on);
          if (module_average !== want.avg)
            flag_mismatch("module_average", want.avg, module_average);
          if (no_valid_data !== want.nodata)
            flag_mismatch("no_valid_data", want.nodata, no_valid_data);
          if (last_decision !== want.fin)
            flag_mismatch("last_decision", want.fin, last_decision);
        end
      end
    end
  end

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {index, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) flag_mismatch("register readback", value, prdata);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic set_config(input logic en, input logic [15:0] thr, input logic [15:0] mark);
    write_register(pcbd_pkg::REG_ENABLE, {31'd0, en});
    write_register(pcbd_pkg::REG_THRESHOLD, {16'd0, thr});
    write_register(pcbd_pkg::REG_MARKER, {16'd0, mark});
    cfg_enable = en;
    cfg_threshold = thr;
    cfg_marker = mark;
  endtask

  task automatic wait_idle();
    while (tap_queue.size() != 0 || start || decisions_due.size() != 0 || busy)
      @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic void push_sample(input logic [5:0] idx, input logic [15:0] volt,
                                      input logic last);
    tap_queue.push_back('{idx, volt, last});
  endfunction

  // one pack scan: clustered readings, some noise, invalid markers and stray modules
  function automatic int queue_scan();
    int          len;
    int          k;
    int          base;
    logic [5:0]  idx;
    logic [15:0] volt;
    len = $urandom_range(1, 30);
    base = $urandom_range(0, 65535 - 700);
    for (k = 0; k < len; k++) begin
      idx = ($urandom_range(99) < 8) ? 6'($urandom_range(63))
                                     : 6'($urandom_range(pcbd_pkg::MODULES - 1));
      case ($urandom_range(9))
        0:       volt = 16'($urandom_range(65535));
        1:       volt = cfg_marker;
        default: volt = 16'(base + $urandom_range(600));
      endcase
      push_sample(idx, volt, k == len - 1);
    end
    return len;
  endfunction

  task automatic random_phase(input logic en, input logic [15:0] thr,
                              input logic [15:0] mark, input int gaps);
    int n;
    set_config(en, thr, mark);
    gap_pct = gaps;
    n = 0;
    while (n < 18) n += queue_scan();
    wait_idle();
  endtask

  initial begin
    clear_pass();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // reset settings: balancing off, zero reading is invalid
    push_sample(6'd2, 16'd1000, 1'b0);
    push_sample(6'd5, 16'd0, 1'b0);
    push_sample(6'd63, 16'hFFFF, 1'b1);
    push_sample(6'd0, 16'd0, 1'b1);
    repeat (17) push_sample(6'd7, 16'hFFFF, 1'b0);
    push_sample(6'd7, 16'd1, 1'b1);
    wait_idle();

    set_config(1'b1, 16'd0, 16'hFFFF);
    push_sample(6'd1, 16'd0, 1'b0);
    push_sample(6'd4, 16'hFFFF, 1'b0);
    push_sample(6'd6, 16'd5, 1'b1);
    wait_idle();

    random_phase(1'b1, 16'($urandom_range(400)), 16'($urandom_range(65535)), 18);
    random_phase(1'b1, 16'hFFFF, 16'd0, 0);
    random_phase(1'b0, 16'($urandom_range(400)), 16'($urandom_range(65535)), 18);
    random_phase(1'b1, 16'($urandom_range(300)), 16'hFFFF, 18);

    if (mismatch_count == 0 && decisions_due.size() == 0) begin
      $display("passive_cell_balance_decider_test passed");
    end else begin
      $display("passive_cell_balance_decider_test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("passive_cell_balance_decider_test failed");
    $finish;
  end

endmodule
